[rtl/eiphx_pkg.sv]
// ----------------------------------------------------------------------------
// eiphx_pkg
// Shared types and constants of the Ethernet/IPv4 port header extractor:
// frame offsets, protocol codes, status codes and the result record.
// ----------------------------------------------------------------------------
package eiphx_pkg;

   // Byte counter width; the count saturates at its all-ones value.
   localparam int unsigned COUNT_W = 7;

   // Frame offsets and length thresholds, in bytes.
   localparam logic [COUNT_W-1:0] ETH_HDR_END  = 7'd14;
   localparam logic [COUNT_W-1:0] PROTO_AT     = 7'd23;
   localparam logic [COUNT_W-1:0] SRC_IP_AT    = 7'd26;
   localparam logic [COUNT_W-1:0] DST_IP_AT    = 7'd30;
   localparam logic [COUNT_W-1:0] IP_MIN_END   = 7'd34;
   localparam logic [COUNT_W-1:0] PORT_BYTES   = 7'd4;
   localparam logic [COUNT_W-1:0] TCP_MIN      = 7'd20;
   localparam logic [COUNT_W-1:0] UDP_MIN      = 7'd8;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'd127;

   // Header codes.
   localparam logic [15:0] KIND_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   // Register file: two registers at word addresses, index taken from paddr[2].
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic REG_TCP_SEL = 1'b0;
   localparam logic REG_UDP_SEL = 1'b1;

   typedef enum logic [2:0] {
      STATUS_SHORT_FRAME = 3'd0,
      STATUS_NOT_IPV4    = 3'd1,
      STATUS_SHORT_IP    = 3'd2,
      STATUS_IP_ONLY     = 3'd3,
      STATUS_SHORT_TCP   = 3'd4,
      STATUS_TCP         = 3'd5,
      STATUS_SHORT_UDP   = 3'd6,
      STATUS_UDP         = 3'd7
   } parse_status_type;

   typedef struct packed {
      logic tcp_ports_on;
      logic udp_ports_on;
   } port_select_type;

   typedef struct packed {
      logic [47:0]      dest_mac;
      logic [47:0]      source_mac;
      logic [15:0]      ether_kind;
      logic [31:0]      source_ip;
      logic [31:0]      dest_ip;
      logic [7:0]       ip_protocol;
      logic [15:0]      source_port;
      logic [15:0]      dest_port;
      parse_status_type parse_status;
   } header_result_type;

endpackage

[rtl/eiphx_intf.sv]
// ----------------------------------------------------------------------------
// eiphx_intf
// Valid/ready channels of the extractor: frame bytes in, header records out.
// ----------------------------------------------------------------------------
interface eiphx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface eiphx_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] dest_mac;
   logic [47:0] source_mac;
   logic [15:0] ether_kind;
   logic [31:0] source_ip;
   logic [31:0] dest_ip;
   logic [7:0]  ip_protocol;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [2:0]  parse_status;

   modport source (output valid, output dest_mac, output source_mac, output ether_kind,
                   output source_ip, output dest_ip, output ip_protocol,
                   output source_port, output dest_port, output parse_status,
                   input ready);
   modport sink   (input valid, input dest_mac, input source_mac, input ether_kind,
                   input source_ip, input dest_ip, input ip_protocol,
                   input source_port, input dest_port, input parse_status,
                   output ready);
endinterface

[rtl/eiphx_parser.sv]
// ----------------------------------------------------------------------------
// eiphx_parser
// Per-frame capture state. Each stepped byte is placed into its header field
// by offset; on the last byte the frame status is worked out and the state
// is cleared for the next frame.
// ----------------------------------------------------------------------------
module eiphx_parser import eiphx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        frame_byte,
   input  logic              frame_last,
   input  port_select_type   port_select,
   output header_result_type result
);

   logic [COUNT_W-1:0] byte_index_ff, byte_index_in;
   logic [3:0]         header_words_ff, header_words_in;
   logic [47:0]        dest_mac_ff, dest_mac_in;
   logic [47:0]        source_mac_ff, source_mac_in;
   logic [15:0]        ether_kind_ff, ether_kind_in;
   logic [31:0]        source_ip_ff, source_ip_in;
   logic [31:0]        dest_ip_ff, dest_ip_in;
   logic [7:0]         protocol_ff, protocol_in;
   logic [31:0]        ports_ff, ports_in;

   // Field values with the current byte folded in, before any clearing.
   logic [COUNT_W-1:0] len;
   logic [3:0]         cap_words;
   logic [47:0]        cap_dest_mac;
   logic [47:0]        cap_source_mac;
   logic [15:0]        cap_kind;
   logic [31:0]        cap_source_ip;
   logic [31:0]        cap_dest_ip;
   logic [7:0]         cap_protocol;
   logic [31:0]        cap_ports;
   logic               capture;
   logic [COUNT_W-1:0] port_at;
   logic [COUNT_W-1:0] port_rel;
   logic               in_ports;
   logic [COUNT_W-1:0] l4_start;
   parse_status_type   status;
   logic               ip_ok;
   logic               ports_ok;

   // Capture of the current byte at its big-endian position.
   always_comb begin
      capture        = (byte_index_ff != COUNT_MAX);
      cap_words      = header_words_ff;
      cap_dest_mac   = dest_mac_ff;
      cap_source_mac = source_mac_ff;
      cap_kind       = ether_kind_ff;
      cap_source_ip  = source_ip_ff;
      cap_dest_ip    = dest_ip_ff;
      cap_protocol   = protocol_ff;
      cap_ports      = ports_ff;

      for (int i = 0; i < 6; i++) begin
         if (capture && byte_index_ff == COUNT_W'(i)) begin
            cap_dest_mac[8*(5-i) +: 8] = dest_mac_ff[8*(5-i) +: 8] | frame_byte;
         end
         if (capture && byte_index_ff == COUNT_W'(i + 6)) begin
            cap_source_mac[8*(5-i) +: 8] = source_mac_ff[8*(5-i) +: 8] | frame_byte;
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (capture && byte_index_ff == COUNT_W'(i + 12)) begin
            cap_kind[8*(1-i) +: 8] = ether_kind_ff[8*(1-i) +: 8] | frame_byte;
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (capture && byte_index_ff == SRC_IP_AT + COUNT_W'(i)) begin
            cap_source_ip[8*(3-i) +: 8] = source_ip_ff[8*(3-i) +: 8] | frame_byte;
         end
         if (capture && byte_index_ff == DST_IP_AT + COUNT_W'(i)) begin
            cap_dest_ip[8*(3-i) +: 8] = dest_ip_ff[8*(3-i) +: 8] | frame_byte;
         end
      end
      if (capture && byte_index_ff == PROTO_AT) begin
         cap_protocol = frame_byte;
      end
      if (capture && byte_index_ff == ETH_HDR_END) begin
         cap_words = frame_byte[3:0];
      end

      // The port words follow the IP header, whose length is taken unchecked.
      port_at  = ETH_HDR_END + {1'b0, cap_words, 2'b00};
      port_rel = byte_index_ff - port_at;
      in_ports = capture && (byte_index_ff >= ETH_HDR_END) && (byte_index_ff >= port_at)
                 && (byte_index_ff < port_at + PORT_BYTES);
      for (int i = 0; i < 4; i++) begin
         if (in_ports && port_rel[1:0] == 2'(i)) begin
            cap_ports[8*(3-i) +: 8] = ports_ff[8*(3-i) +: 8] | frame_byte;
         end
      end

      len = (byte_index_ff == COUNT_MAX) ? COUNT_MAX : byte_index_ff + 1'b1;
   end

   // Frame status from the saturated length and the captured header.
   always_comb begin
      l4_start = ETH_HDR_END + {1'b0, cap_words, 2'b00};
      if (len < ETH_HDR_END) begin
         status = STATUS_SHORT_FRAME;
      end else if (cap_kind != KIND_IPV4) begin
         status = STATUS_NOT_IPV4;
      end else if (len < IP_MIN_END) begin
         status = STATUS_SHORT_IP;
      end else if (port_select.tcp_ports_on && cap_protocol == PROTO_TCP) begin
         status = (len < l4_start + TCP_MIN) ? STATUS_SHORT_TCP : STATUS_TCP;
      end else if (port_select.udp_ports_on && cap_protocol == PROTO_UDP) begin
         status = (len < l4_start + UDP_MIN) ? STATUS_SHORT_UDP : STATUS_UDP;
      end else begin
         status = STATUS_IP_ONLY;
      end
      ip_ok    = (status != STATUS_SHORT_FRAME) && (status != STATUS_NOT_IPV4)
                 && (status != STATUS_SHORT_IP);
      ports_ok = (status == STATUS_TCP) || (status == STATUS_UDP);

      result.dest_mac     = cap_dest_mac;
      result.source_mac   = cap_source_mac;
      result.ether_kind   = cap_kind;
      result.source_ip    = ip_ok ? cap_source_ip : '0;
      result.dest_ip      = ip_ok ? cap_dest_ip : '0;
      result.ip_protocol  = ip_ok ? cap_protocol : '0;
      result.source_port  = ports_ok ? cap_ports[31:16] : '0;
      result.dest_port    = ports_ok ? cap_ports[15:0] : '0;
      result.parse_status = status;
   end

   // Next state: hold when idle, take the capture, clear after the last byte.
   always_comb begin
      byte_index_in   = byte_index_ff;
      header_words_in = header_words_ff;
      dest_mac_in     = dest_mac_ff;
      source_mac_in   = source_mac_ff;
      ether_kind_in   = ether_kind_ff;
      source_ip_in    = source_ip_ff;
      dest_ip_in      = dest_ip_ff;
      protocol_in     = protocol_ff;
      ports_in        = ports_ff;
      if (step && frame_last) begin
         byte_index_in   = '0;
         header_words_in = '0;
         dest_mac_in     = '0;
         source_mac_in   = '0;
         ether_kind_in   = '0;
         source_ip_in    = '0;
         dest_ip_in      = '0;
         protocol_in     = '0;
         ports_in        = '0;
      end else if (step) begin
         byte_index_in   = len;
         header_words_in = cap_words;
         dest_mac_in     = cap_dest_mac;
         source_mac_in   = cap_source_mac;
         ether_kind_in   = cap_kind;
         source_ip_in    = cap_source_ip;
         dest_ip_in      = cap_dest_ip;
         protocol_in     = cap_protocol;
         ports_in        = cap_ports;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= '0;
         header_words_ff <= '0;
         dest_mac_ff     <= '0;
         source_mac_ff   <= '0;
         ether_kind_ff   <= '0;
         source_ip_ff    <= '0;
         dest_ip_ff      <= '0;
         protocol_ff     <= '0;
         ports_ff        <= '0;
      end else begin
         byte_index_ff   <= byte_index_in;
         header_words_ff <= header_words_in;
         dest_mac_ff     <= dest_mac_in;
         source_mac_ff   <= source_mac_in;
         ether_kind_ff   <= ether_kind_in;
         source_ip_ff    <= source_ip_in;
         dest_ip_ff      <= dest_ip_in;
         protocol_ff     <= protocol_in;
         ports_ff        <= ports_in;
      end
   end

endmodule

[rtl/ethernet_ipv4_port_header_extractor_unit.sv]
// ----------------------------------------------------------------------------
// ethernet_ipv4_port_header_extractor_unit
// Extracts Ethernet, IPv4 and TCP/UDP port header fields from a byte stream
// and delivers one header record with a parse status per frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle on req, except while a last byte
// waits in the input register. Each byte is held in the input register; for
// a byte marked last, the capture and status logic then loads the result
// register, which offers the header record on rsp until it is taken.
// Bytes that are not last produce nothing and never stall. A last byte waits
// in the input register only while the result register still holds a record
// that has not been taken. Port extraction for TCP and UDP is enabled by the
// TCP select register (address 0) and the UDP select register (address 4),
// which should be written only while no frame is in progress.
// ----------------------------------------------------------------------------
module ethernet_ipv4_port_header_extractor_unit import eiphx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   eiphx_req_if.sink             req,
   eiphx_rsp_if.source           rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic              tcp_sel_ff, tcp_sel_in;
   logic              udp_sel_ff, udp_sel_in;
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   header_result_type rsp_data_ff;
   header_result_type frame_result;
   port_select_type   port_select;
   logic              out_free;
   logic              step;
   logic              csr_write;

   // Register file writes and reads.
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      tcp_sel_in = tcp_sel_ff;
      udp_sel_in = udp_sel_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_TCP_SEL: tcp_sel_in = pwdata[0];
            REG_UDP_SEL: udp_sel_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         REG_TCP_SEL: prdata[0] = tcp_sel_ff;
         REG_UDP_SEL: prdata[0] = udp_sel_ff;
         default: ;
      endcase
   end

   // Handshake: the input register moves on unless a last item finds the
   // result register occupied.
   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign step         = in_valid_ff && (!in_last_ff || out_free);
   assign req.ready    = !in_valid_ff || step;
   assign in_valid_in  = req.valid ? 1'b1 : (in_valid_ff && !step);
   assign rsp_valid_in = (step && in_last_ff) ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   assign port_select.tcp_ports_on = tcp_sel_ff;
   assign port_select.udp_ports_on = udp_sel_ff;

   eiphx_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .frame_byte  (in_byte_ff),
      .frame_last  (in_last_ff),
      .port_select (port_select),
      .result      (frame_result)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tcp_sel_ff   <= 1'b0;
         udp_sel_ff   <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tcp_sel_ff   <= tcp_sel_in;
         udp_sel_ff   <= udp_sel_in;
         in_valid_ff  <= (req.valid && req.ready) ? 1'b1 : in_valid_in && !step;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.frame_byte;
         in_last_ff <= req.frame_last;
      end
      if (step && in_last_ff) begin
         rsp_data_ff <= frame_result;
      end
   end

   // Result channel.
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.dest_mac     = rsp_data_ff.dest_mac;
   assign rsp.source_mac   = rsp_data_ff.source_mac;
   assign rsp.ether_kind   = rsp_data_ff.ether_kind;
   assign rsp.source_ip    = rsp_data_ff.source_ip;
   assign rsp.dest_ip      = rsp_data_ff.dest_ip;
   assign rsp.ip_protocol  = rsp_data_ff.ip_protocol;
   assign rsp.source_port  = rsp_data_ff.source_port;
   assign rsp.dest_port    = rsp_data_ff.dest_port;
   assign rsp.parse_status = rsp_data_ff.parse_status;

endmodule
